@@ rtl/core/dcso_pkg.sv @@
// Shared types and constants for the distributed-clock sync offset block.
// Used by dcso_ctrl, dcso_dp and dc_clock_sync_offset. No dependencies.

package dcso_pkg;

   localparam int RefW = 63;
   localparam int CycW = 30;
   localparam int OffW = 32;
   localparam int IntW = 32;

   localparam logic [CycW-1:0] CYCLE_RESET = 30'd1000000;
   localparam logic [RefW-1:0] SYNC_SHIFT  = 63'd50000;

   // restoring remainder: one dividend bit per step
   localparam int DivSteps = RefW;
   localparam int CntW     = $clog2(DivSteps);

   // truncating division by constants: q = (x * RECIP) >> SHIFT
   // err magnitude < 2^30 for /100, integral magnitude <= 2^31 for /20
   localparam logic [31:0] ERR_RECIP = 32'd1374389535;
   localparam int          ErrShift  = 37;
   localparam logic [31:0] INT_RECIP = 32'd3435973837;
   localparam int          IntShift  = 36;

   localparam logic signed [IntW-1:0] INT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [IntW-1:0] INT_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic load;
      logic step;
      logic fix;
      logic mul_err;
      logic mul_int;
      logic publish;
   } dcso_cmd_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DIVIDE = 6'b000010,
      ST_FIX    = 6'b000100,
      ST_MUL_E  = 6'b001000,
      ST_MUL_I  = 6'b010000,
      ST_DONE   = 6'b100000
   } dcso_state_type;

endpackage

@@ rtl/core/dc_clock_sync_offset.sv @@
// Distributed-clock sync offset: one item in, one offset out.
// Each item runs through the 63-step serial remainder, sign fix, two
// multiplier passes and the output load before rsp_valid rises.
// One item at a time; the next item is taken while a result waits.
// Synchronous active-high reset: cycle_time 1000000, integral zero, no result.
// Depends on dcso_pkg, dcso_ctrl and dcso_dp.

module dc_clock_sync_offset (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [dcso_pkg::RefW-1:0]        req_ref_time,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [dcso_pkg::OffW-1:0] rsp_offset_time,
   input  logic                             csr_wr_en,
   input  logic [dcso_pkg::CycW-1:0]        csr_wr_data
);
   import dcso_pkg::*;

   dcso_cmd_type cmd;

   dcso_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   dcso_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_ref_time    (req_ref_time),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_offset_time (rsp_offset_time)
   );

endmodule

@@ rtl/core/dcso_ctrl.sv @@
// Sequencer for the sync offset block: handshakes and datapath commands.
// Depends on dcso_pkg.

module dcso_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dcso_pkg::dcso_cmd_type cmd
);
   import dcso_pkg::*;

   dcso_state_type  state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            accept;
   logic            out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CntW'(DivSteps - 1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = ST_MUL_E;
         end
         ST_MUL_E: begin
            cmd.mul_err = 1'b1;
            state_in    = ST_MUL_I;
         end
         ST_MUL_I: begin
            cmd.mul_int = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_cmd_onehot0: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done state");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (cnt_ff <= CntW'(DivSteps - 1)))
      else $error("divide step count overran");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_DIVIDE) && (cnt_ff == '0))
      else $error("accepted item did not start the divide");
`endif

endmodule

@@ rtl/core/dcso_dp.sv @@
// Datapath: cycle-time register, serial remainder, phase error, integral
// counter, shared constant-reciprocal multiplier and output register.
// Depends on dcso_pkg.

module dcso_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  dcso_pkg::dcso_cmd_type              cmd,
   input  logic [dcso_pkg::RefW-1:0]           req_ref_time,
   input  logic                                csr_wr_en,
   input  logic [dcso_pkg::CycW-1:0]           csr_wr_data,
   output logic signed [dcso_pkg::OffW-1:0]    rsp_offset_time
);
   import dcso_pkg::*;

   logic [CycW-1:0]        cycle_ff;
   logic [RefW-1:0]        dvd_ff;
   logic                   neg_ff;
   logic [CycW-1:0]        rem_ff;
   logic signed [IntW-1:0] err_ff;
   logic signed [IntW-1:0] integ_ff, integ_in;
   logic [63:0]            prod_ff;
   logic [OffW-1:0]        qe_ff;
   logic signed [OffW-1:0] offset_ff;

   logic [RefW:0]          diff;
   logic [RefW-1:0]        mag;
   logic [CycW:0]          trial;
   logic [CycW:0]          rem_next;
   logic signed [IntW-1:0] rem_s;
   logic signed [IntW-1:0] half_s;
   logic signed [IntW-1:0] err_raw;
   logic signed [IntW-1:0] err_fix;
   logic [31:0]            err_abs;
   logic [31:0]            integ_abs;
   logic [31:0]            mul_a;
   logic [31:0]            mul_b;
   logic [OffW-1:0]        qi;
   logic signed [OffW-1:0] corr;

   // dividend magnitude and sign of ref_time - shift
   always_comb begin
      diff = {1'b0, req_ref_time} - {1'b0, SYNC_SHIFT};
      mag  = diff[RefW] ? (SYNC_SHIFT - req_ref_time) : diff[RefW-1:0];
   end

   // one restoring step of the remainder
   always_comb begin
      trial    = {rem_ff, dvd_ff[RefW-1]};
      rem_next = (trial >= {1'b0, cycle_ff}) ? (trial - {1'b0, cycle_ff}) : trial;
   end

   // phase error with sign, half-cycle wrap, and saturating integral
   always_comb begin
      rem_s   = $signed({{(IntW-CycW){1'b0}}, rem_ff});
      half_s  = $signed({{(IntW-CycW){1'b0}}, cycle_ff >> 1});
      err_raw = neg_ff ? -rem_s : rem_s;
      if (cycle_ff == '0) begin
         err_fix = '0;
      end else if (err_raw > half_s) begin
         err_fix = err_raw - $signed({{(IntW-CycW){1'b0}}, cycle_ff});
      end else begin
         err_fix = err_raw;
      end
      integ_in = integ_ff;
      if (err_fix > 0 && integ_ff != INT_MAX) begin
         integ_in = integ_ff + 1;
      end else if (err_fix < 0 && integ_ff != INT_MIN) begin
         integ_in = integ_ff - 1;
      end
   end

   // shared multiplier: error magnitude first, then integral magnitude
   always_comb begin
      err_abs   = err_ff[IntW-1] ? 32'(-err_ff) : 32'(err_ff);
      integ_abs = integ_ff[IntW-1] ? 32'(-integ_ff) : 32'(integ_ff);
      mul_a     = cmd.mul_int ? integ_abs : err_abs;
      mul_b     = cmd.mul_int ? INT_RECIP : ERR_RECIP;
   end

   always_comb begin
      qi   = OffW'(prod_ff >> IntShift);
      corr = (err_ff[IntW-1] ? $signed(qe_ff) : -$signed(qe_ff))
           + (integ_ff[IntW-1] ? $signed(qi) : -$signed(qi));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_ff <= CYCLE_RESET;
         integ_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            cycle_ff <= csr_wr_data;
         end
         if (cmd.fix) begin
            integ_ff <= integ_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dvd_ff <= mag;
         neg_ff <= diff[RefW];
         rem_ff <= '0;
      end else if (cmd.step) begin
         dvd_ff <= {dvd_ff[RefW-2:0], 1'b0};
         rem_ff <= rem_next[CycW-1:0];
      end
      if (cmd.fix) begin
         err_ff <= err_fix;
      end
      if (cmd.mul_err || cmd.mul_int) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.mul_int) begin
         qe_ff <= OffW'(prod_ff >> ErrShift);
      end
      if (cmd.publish) begin
         offset_ff <= corr;
      end
   end

   assign rsp_offset_time = offset_ff;

endmodule
